// ----- rtl/ictp_pkg.sv -----
// ----------------------------------------------------------------------------
// ictp_pkg
// Shared types, constants and tree pseudo-LRU helpers of the instruction
// cache tag directory.
// ----------------------------------------------------------------------------
package ictp_pkg;

  // geometry (number of sets is a power of two)
  localparam int NUM_SETS  = 128;
  localparam int NUM_WAYS  = 8;
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int ADDR_BITS = 32;
  localparam int OFFS_BITS = 5;
  localparam int LINE_BITS = ADDR_BITS - OFFS_BITS;
  localparam int TAG_BITS  = LINE_BITS - SET_BITS;
  localparam int LRU_BITS  = NUM_WAYS - 1;

  localparam logic [NUM_WAYS-1:0] ALL_VALID = 8'hff;
  localparam logic [LRU_BITS-1:0] LRU_MASK  = 7'h7f;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCK   = 8'd1;

  // input action codes
  localparam logic ACT_READ       = 1'b0;
  localparam logic ACT_INVALIDATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_HIT    = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_BYPASS = 2'd2,
    STATUS_INVAL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EVAL  = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;   // zero the valid and tree bits of one set
    logic load;    // capture command and read the set
    logic commit;  // resolve, update the set, present the result
  } cmd_t;

  // tree bits cleared when a way is touched
  function automatic logic [LRU_BITS-1:0] touch_mask(input logic [WAY_BITS-1:0] w);
    logic [LRU_BITS-1:0] m;
    unique case (w)
      3'd0, 3'd1: m = 7'd11;
      3'd2, 3'd3: m = 7'd19;
      3'd4, 3'd5: m = 7'd37;
      default:    m = 7'd69;
    endcase
    return m;
  endfunction

  // tree bits set when a way is touched
  function automatic logic [LRU_BITS-1:0] touch_value(input logic [WAY_BITS-1:0] w);
    logic [LRU_BITS-1:0] v;
    unique case (w)
      3'd0:    v = 7'd11;
      3'd1:    v = 7'd3;
      3'd2:    v = 7'd17;
      3'd3:    v = 7'd1;
      3'd4:    v = 7'd36;
      3'd5:    v = 7'd4;
      3'd6:    v = 7'd64;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // walk the tree to the victim way
  function automatic logic [WAY_BITS-1:0] tree_victim(input logic [LRU_BITS-1:0] t);
    logic [WAY_BITS-1:0] w;
    if (t[0]) begin
      if (t[2]) w = t[6] ? 3'd7 : 3'd6;
      else      w = t[5] ? 3'd5 : 3'd4;
    end else begin
      if (t[1]) w = t[4] ? 3'd3 : 3'd2;
      else      w = t[3] ? 3'd1 : 3'd0;
    end
    return w;
  endfunction

  // lowest clear bit among the first seven, top way otherwise
  function automatic logic [WAY_BITS-1:0] lowest_invalid(input logic [NUM_WAYS-1:0] v);
    logic [WAY_BITS-1:0] w;
    w = WAY_BITS'(NUM_WAYS - 1);
    for (int i = NUM_WAYS - 2; i >= 0; i--) begin
      if (!v[i]) w = WAY_BITS'(i);
    end
    return w;
  endfunction

endpackage

// ----- rtl/ictp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ictp_ctrl
// Command sequencer: clears the sets after reset, then takes a command and
// resolves it in the evaluate state.
// ----------------------------------------------------------------------------
module ictp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            clear_last,
  output logic            busy,
  output ictp_pkg::cmd_t  cmd
);

  ictp_pkg::state_t state;
  ictp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ictp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ictp_pkg::ST_CLEAR: begin
        if (clear_last) state_next = ictp_pkg::ST_IDLE;
      end
      ictp_pkg::ST_IDLE: begin
        if (start) state_next = ictp_pkg::ST_EVAL;
      end
      ictp_pkg::ST_EVAL: begin
        state_next = ictp_pkg::ST_IDLE;
      end
      default: begin
        state_next = ictp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.clear  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    busy       = 1'b0;
    unique case (state)
      ictp_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        busy      = 1'b1;
      end
      ictp_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      ictp_pkg::ST_EVAL: begin
        cmd.commit = 1'b1;
        busy       = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/ictp_dpath.sv -----
// ----------------------------------------------------------------------------
// ictp_dpath
// Tag, valid and tree pseudo-LRU storage, tag compare, victim choice and
// the result register; holds the configuration registers.
// ----------------------------------------------------------------------------
module ictp_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ictp_pkg::cmd_t                        cmd,
  input  logic                                  action,
  input  logic [ictp_pkg::ADDR_BITS-1:0]        address,
  input  logic                                  cfg_write,
  input  logic [ictp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ictp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                  clear_last,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [ictp_pkg::WAY_BITS-1:0]         way,
  output logic [ictp_pkg::LINE_BITS-1:0]        line_number
);

  localparam int NW = ictp_pkg::NUM_WAYS;
  localparam int WB = ictp_pkg::WAY_BITS;
  localparam int SB = ictp_pkg::SET_BITS;
  localparam int TB = ictp_pkg::TAG_BITS;
  localparam int LB = ictp_pkg::LRU_BITS;

  // storage
  logic [NW-1:0][TB-1:0] tag_mem   [ictp_pkg::NUM_SETS];
  logic [NW-1:0]         way_valid [ictp_pkg::NUM_SETS];
  logic [LB-1:0]         tree_lru  [ictp_pkg::NUM_SETS];

  logic cache_enable;
  logic cache_lock;

  // set walked by the clearing pass
  logic [SB-1:0] clear_set;

  // captured command and set snapshot
  logic                          action_q;
  logic [ictp_pkg::LINE_BITS-1:0] line_q;
  logic [NW-1:0][TB-1:0]         tag_row_q;
  logic [NW-1:0]                 valid_q;
  logic [LB-1:0]                 lru_q;

  logic [SB-1:0] in_set;
  logic [SB-1:0] set_q;
  logic [TB-1:0] tag_q;

  logic [NW-1:0] hit_vec;
  logic          hit;
  logic [WB-1:0] hit_way;
  logic [WB-1:0] alloc_way;
  logic [NW-1:0] alloc_onehot;
  logic [WB-1:0] sel_way;
  logic          is_read;
  logic          alloc;
  logic          touch;
  ictp_pkg::status_t status_next;
  ictp_pkg::status_t status_q;
  logic [WB-1:0] way_next;

  assign in_set = address[ictp_pkg::OFFS_BITS +: SB];
  assign set_q  = line_q[SB-1:0];
  assign tag_q  = line_q[ictp_pkg::LINE_BITS-1:SB];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b0;
      cache_lock   <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == ictp_pkg::CFG_ENABLE) cache_enable <= cfg_data[0];
      else if (cfg_index == ictp_pkg::CFG_LOCK) cache_lock <= cfg_data[0];
    end
  end

  // clearing pass, one set per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_set <= '0;
    end else if (cmd.clear) begin
      clear_set <= clear_set + SB'(1);
    end
  end

  assign clear_last = (clear_set == SB'(ictp_pkg::NUM_SETS - 1));

  // command capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      line_q   <= address[ictp_pkg::ADDR_BITS-1:ictp_pkg::OFFS_BITS];
    end
  end

  // tag memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_row_q <= tag_mem[in_set];
    end
    if (cmd.commit && alloc) begin
      tag_mem[set_q][alloc_way] <= tag_q;
    end
  end

  // valid and tree bits, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      way_valid[clear_set] <= '0;
      tree_lru[clear_set]  <= '0;
    end else if (cmd.commit) begin
      if (action_q == ictp_pkg::ACT_INVALIDATE && cache_enable) begin
        way_valid[set_q] <= '0;
      end else if (alloc) begin
        way_valid[set_q] <= valid_q | alloc_onehot;
      end
      if (touch) begin
        tree_lru[set_q] <= ((lru_q & ~ictp_pkg::touch_mask(sel_way))
                            | ictp_pkg::touch_value(sel_way)) & ictp_pkg::LRU_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      valid_q <= way_valid[in_set];
      lru_q   <= tree_lru[in_set];
    end
  end

  // compare and decide
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      hit_vec[w] = valid_q[w] && (tag_row_q[w] == tag_q);
    end
    hit     = |hit_vec;
    hit_way = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WB'(w);
    end
    alloc_way = (valid_q == ictp_pkg::ALL_VALID) ? ictp_pkg::tree_victim(lru_q)
                                                 : ictp_pkg::lowest_invalid(valid_q);
    alloc_onehot = NW'(1) << alloc_way;
    is_read  = (action_q == ictp_pkg::ACT_READ);
    alloc    = is_read && cache_enable && !hit && !cache_lock;
    touch    = is_read && cache_enable && (hit || !cache_lock);
    sel_way  = hit ? hit_way : alloc_way;
    way_next = touch ? sel_way : '0;
    if (!is_read)          status_next = ictp_pkg::STATUS_INVAL;
    else if (!cache_enable) status_next = ictp_pkg::STATUS_BYPASS;
    else if (hit)          status_next = ictp_pkg::STATUS_HIT;
    else if (cache_lock)   status_next = ictp_pkg::STATUS_BYPASS;
    else                   status_next = ictp_pkg::STATUS_MISS;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_q    <= status_next;
      way         <= way_next;
      line_number <= line_q;
    end
  end

  assign status = status_q;

  // at most one way can match a tag
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $onehot0(hit_vec))
    else $error("several ways hit");

  // allocation never displaces a valid line while a free way exists
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc && valid_q != ictp_pkg::ALL_VALID) |-> !valid_q[alloc_way])
    else $error("allocation over a valid way");

  // bypass and invalidate results carry way zero
  a_way_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ictp_pkg::STATUS_HIT && status != ictp_pkg::STATUS_MISS)
      |-> (way == '0))
    else $error("nonzero way on bypass or invalidate");

endmodule

// ----- rtl/icache_tag_plru_controller.sv -----
// ----------------------------------------------------------------------------
// icache_tag_plru_controller
// Tag directory of an 8-way set-associative instruction cache with tree
// pseudo-LRU replacement.
// ----------------------------------------------------------------------------
// A command (read lookup or set invalidate) is taken at a clock edge with
// start high and busy low. Its result then appears on status, way and
// line_number, with done high for exactly one cycle; the result is never
// held back, so sample it when done is high. busy is high while a command
// is resolved, and a new command can be issued in the cycle that shows the
// previous result. A command is resolved in two steps: a registered read of
// the addressed set (tags, valid bits, tree bits) followed by the compare,
// victim choice and set update. After reset a clearing pass zeroes the
// valid and tree bits of one set per cycle, so busy stays high during reset
// and until the last of the 128 sets is cleared; tags are only trusted
// where valid.
// Registers (index 0 cache_enable, index 1 cache_lock) are written through
// cfg_valid / cfg_ready, which is always ready; write them only when no
// command is in flight. Writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module icache_tag_plru_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  // command beat
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action,
  input  logic [ictp_pkg::ADDR_BITS-1:0]        address,
  // result beat
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [ictp_pkg::WAY_BITS-1:0]         way,
  output logic [ictp_pkg::LINE_BITS-1:0]        line_number,
  // configuration write beat
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ictp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ictp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  ictp_pkg::cmd_t cmd;
  logic           clear_last;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  // sequencer: clear / idle / resolve
  ictp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .clear_last (clear_last),
    .busy       (busy),
    .cmd        (cmd)
  );

  // storage, compare, replacement and result register
  ictp_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .address     (address),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .clear_last  (clear_last),
    .done        (done),
    .status      (status),
    .way         (way),
    .line_number (line_number)
  );

  // a result beat lands in an idle cycle, so a new command can go with it
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

endmodule
